FILE: src/fdem_pkg.sv
// ----------------------------------------------------------------------------
// Forward-difference edge magnitude package
// Shared types, constants and helpers for the edge magnitude block.
// ----------------------------------------------------------------------------
package fdem_pkg;

   localparam int PIXEL_BITS       = 8;
   localparam int GRAD_BITS        = PIXEL_BITS + 1;
   localparam int CFG_BITS         = 11;
   localparam int CSR_INDEX_BITS   = 1;
   localparam int MAX_WIDTH_DEF    = 1024;
   localparam int MAX_HEIGHT       = 1024;
   localparam int ROW_BITS         = $clog2(MAX_HEIGHT);

   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_HEIGHT = 1'b1;

   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_DRAIN = 1'b1;

   typedef struct packed {
      logic                  command;
      logic [PIXEL_BITS-1:0] pixel;
   } fdem_req_type;

   typedef struct packed {
      logic [GRAD_BITS-1:0] gradient;
      logic                 frame_end;
   } fdem_rsp_type;

   function automatic logic [PIXEL_BITS-1:0] abs_diff(
      input logic [PIXEL_BITS-1:0] a,
      input logic [PIXEL_BITS-1:0] b
   );
      logic [PIXEL_BITS-1:0] d;
      d = (a > b) ? (a - b) : (b - a);
      return d;
   endfunction

endpackage

FILE: src/fdem_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds when idle.
// ----------------------------------------------------------------------------
module fdem_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/fdem_skid.sv
// ----------------------------------------------------------------------------
// Edge magnitude result buffer
// Output register with one skid entry so a new item can be taken while a
// result waits on a stalled receiver.
// ----------------------------------------------------------------------------
module fdem_skid (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  fdem_pkg::fdem_rsp_type push_data,
   output logic                   full,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output fdem_pkg::fdem_rsp_type rsp
);
   import fdem_pkg::*;

   logic         out_valid_ff, out_valid_in;
   logic         skid_valid_ff, skid_valid_in;
   fdem_rsp_type out_data_ff, out_data_in;
   fdem_rsp_type skid_data_ff, skid_data_in;
   logic         pop;

   assign pop = out_valid_ff && !rsp_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_data_in  = push_data;
            out_valid_in = 1'b1;
         end else begin
            skid_data_in  = push_data;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign full      = skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp       = out_data_ff;

endmodule

FILE: src/forward_difference_edge_magnitude.sv
// ----------------------------------------------------------------------------
// Forward-difference edge magnitude
// Line-buffered |right difference| + |down difference| over a raster stream.
// ----------------------------------------------------------------------------
// Pixels enter on the req_ channel in raster order with command CMD_PIXEL.
// The first row only fills the line buffer. Each pixel of a later row gives
// the result for the pixel above it on the rsp_ channel. After the last pixel
// of a frame, send one CMD_DRAIN item per column to release the bottom row;
// the last drain result carries frame_end. Items that do not fit the current
// phase are taken and dropped without a result.
// Image width and height are set through the csr_ port, by the user only between
// items; the block itself does not enforce this. The port is always ready.
// One item is taken per cycle unless req_stall is high. A result is registered
// in the result buffer before it appears on rsp_. The line buffer is one RAM
// with a registered read port that runs one column ahead, so the item at
// column x finds column x+1 waiting. The result path holds two results;
// req_stall rises only when both are occupied behind a stalled receiver.
// Reset returns the block to the top of a frame; line buffer contents are
// not cleared, and values read before being written in a frame are not used.
// ----------------------------------------------------------------------------
module forward_difference_edge_magnitude #(
   parameter int MAX_WIDTH = fdem_pkg::MAX_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  fdem_pkg::fdem_req_type              req,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output fdem_pkg::fdem_rsp_type              rsp,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [fdem_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [fdem_pkg::CFG_BITS-1:0]       csr_data
);
   import fdem_pkg::*;

   localparam int COL_BITS = $clog2(MAX_WIDTH);
   localparam int CMP_BITS = ((COL_BITS > CFG_BITS) ? COL_BITS : CFG_BITS) + 2;

   logic [CFG_BITS-1:0]   width_cfg_ff, width_cfg_in;
   logic [CFG_BITS-1:0]   height_cfg_ff, height_cfg_in;
   logic [COL_BITS-1:0]   col_ff, col_in;
   logic [ROW_BITS-1:0]   row_ff, row_in;
   logic                  draining_ff, draining_in;
   logic [PIXEL_BITS-1:0] cur_ff, cur_in;
   logic [PIXEL_BITS-1:0] p0_ff, p0_in;
   logic [PIXEL_BITS-1:0] p1_ff, p1_in;

   logic [CMP_BITS-1:0]   width_eff;
   logic [CFG_BITS-1:0]   height_eff;
   logic                  accept, is_drain, process, last_col, first_col, last_row;
   logic [PIXEL_BITS-1:0] above, next_above, right, rd_data;
   logic [PIXEL_BITS-1:0] diff_right, diff_down;
   logic                  has_result, skid_full;
   fdem_rsp_type          result;

   always_comb begin
      width_eff = CMP_BITS'(width_cfg_ff);
      if (width_cfg_ff == '0) begin
         width_eff = CMP_BITS'(1);
      end else if (CMP_BITS'(width_cfg_ff) > CMP_BITS'(MAX_WIDTH)) begin
         width_eff = CMP_BITS'(MAX_WIDTH);
      end
      height_eff = height_cfg_ff;
      if (height_cfg_ff == '0) begin
         height_eff = CFG_BITS'(1);
      end else if (height_cfg_ff > CFG_BITS'(MAX_HEIGHT)) begin
         height_eff = CFG_BITS'(MAX_HEIGHT);
      end
   end

   assign csr_ready = 1'b1;

   always_comb begin
      width_cfg_in  = width_cfg_ff;
      height_cfg_in = height_cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  width_cfg_in  = csr_data;
            CSR_IMAGE_HEIGHT: height_cfg_in = csr_data;
            default:          width_cfg_in  = width_cfg_ff;
         endcase
      end
   end

   assign req_stall = skid_full;
   assign accept    = req_valid && !req_stall;
   assign is_drain  = (req.command == CMD_DRAIN);
   assign process   = accept && (is_drain == draining_ff);
   assign first_col = (col_ff == '0);
   assign last_col  = ((CMP_BITS'(col_ff) + CMP_BITS'(1)) >= width_eff);
   assign last_row  = ((CFG_BITS'(row_ff) + CFG_BITS'(1)) >= height_eff);

   assign above      = first_col ? p0_ff : cur_ff;
   assign next_above = first_col ? p1_ff : rd_data;
   assign right      = last_col ? above : next_above;
   assign diff_right = abs_diff(right, above);
   assign diff_down  = is_drain ? '0 : abs_diff(req.pixel, above);

   assign result.gradient  = GRAD_BITS'(diff_right) + GRAD_BITS'(diff_down);
   assign result.frame_end = is_drain && last_col;
   assign has_result       = process && (is_drain || (row_ff != '0));

   always_comb begin
      col_in      = col_ff;
      row_in      = row_ff;
      draining_in = draining_ff;
      cur_in      = cur_ff;
      p0_in       = p0_ff;
      p1_in       = p1_ff;
      if (process) begin
         cur_in = next_above;
         if (!is_drain && first_col) begin
            p0_in = req.pixel;
         end
         if (!is_drain && (col_ff == COL_BITS'(1))) begin
            p1_in = req.pixel;
         end
         if (last_col) begin
            col_in = '0;
            if (is_drain) begin
               row_in      = '0;
               draining_in = 1'b0;
            end else if (last_row) begin
               row_in      = '0;
               draining_in = 1'b1;
            end else begin
               row_in = row_ff + ROW_BITS'(1);
            end
         end else begin
            col_in = col_ff + COL_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_cfg_ff  <= CFG_BITS'(1024);
         height_cfg_ff <= CFG_BITS'(1024);
         col_ff        <= '0;
         row_ff        <= '0;
         draining_ff   <= 1'b0;
         cur_ff        <= '0;
      end else begin
         width_cfg_ff  <= width_cfg_in;
         height_cfg_ff <= height_cfg_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         draining_ff   <= draining_in;
         cur_ff        <= cur_in;
      end
      p0_ff <= p0_in;
      p1_ff <= p1_in;
   end

   fdem_ram #(
      .WIDTH (PIXEL_BITS),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (process && !is_drain),
      .wr_addr (col_ff),
      .wr_data (req.pixel),
      .rd_en   (process),
      .rd_addr (col_ff + COL_BITS'(2)),
      .rd_data (rd_data)
   );

   fdem_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .push      (has_result),
      .push_data (result),
      .full      (skid_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

endmodule
